// ===== sv/nnr_pkg.sv =====
// Package for the nearest-neighbour resize block: widths, codes, FSM states
// and the small arithmetic helpers. No dependencies.
package nnr_pkg;

    localparam int STORE_WORDS = 4096;
    localparam int STORE_AW    = $clog2(STORE_WORDS);
    localparam int WP_W        = STORE_AW + 1;

    localparam int MAX_DIM     = 256;
    localparam int MAX_BATCH   = 16;
    localparam int DIM_W       = 9;
    localparam int BATCH_W     = 5;
    localparam int CNT_W       = 8;
    localparam int BCNT_W      = 4;
    localparam int PIX_W       = 32;

    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    // radix-4 restoring divider for the source index
    localparam int NUM_W       = 2 * CNT_W + 2;
    localparam int DIV_STEPS   = NUM_W / 2;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int REM_W       = DIM_W + 1;

    // address products
    localparam int A1_W        = BCNT_W + DIM_W;
    localparam int A2_W        = A1_W + DIM_W;
    localparam int A3_W        = A2_W + DIM_W;

    typedef enum logic [2:0] {
        REG_IN_HEIGHT,
        REG_IN_WIDTH,
        REG_OUT_HEIGHT,
        REG_OUT_WIDTH,
        REG_CHANNEL_COUNT,
        REG_BATCH_COUNT
    } reg_idx_t;

    typedef enum logic {
        CMD_LOAD,
        CMD_EMIT
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_ROW,
        ST_MUL_COL,
        ST_READ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
    } div_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

    function automatic logic [BATCH_W-1:0] clamp_batch(input logic [BATCH_W-1:0] v);
        logic [BATCH_W-1:0] r;
        r = v;
        if (v == '0)
            r = BATCH_W'(1);
        else if (v > BATCH_W'(MAX_BATCH))
            r = BATCH_W'(MAX_BATCH);
        return r;
    endfunction

    // two quotient bits per call
    function automatic div_t div_step2(input div_t s, input logic [DIM_W-1:0] den);
        div_t r;
        r = s;
        for (int k = 0; k < 2; k++)
        begin
            r.rem = {r.rem[REM_W-2:0], r.num[NUM_W-1]};
            r.num = {r.num[NUM_W-2:0], 1'b0};
            r.quo = {r.quo[NUM_W-2:0], 1'b0};
            if (r.rem >= {1'b0, den})
            begin
                r.rem    = r.rem - {1'b0, den};
                r.quo[0] = 1'b1;
            end
        end
        return r;
    endfunction

    // clamp quotient to the last source index; a single output line maps to 0
    function automatic logic [CNT_W-1:0] src_clamp(input logic [NUM_W-1:0] quo,
                                                  input logic [DIM_W-1:0] in_n,
                                                  input logic [DIM_W-1:0] out_n);
        logic [DIM_W-1:0] top;
        logic [CNT_W-1:0] r;
        top = in_n - DIM_W'(1);
        if (out_n == DIM_W'(1))
            r = '0;
        else if (quo > NUM_W'(top))
            r = top[CNT_W-1:0];
        else
            r = quo[CNT_W-1:0];
        return r;
    endfunction

endpackage

// ===== sv/nearest_neighbor_resize.sv =====
// Nearest-neighbour resize, aligned corners: pixel store, index divider,
// address pipeline and stream ports. Depends on nnr_pkg.
// Emit path: the radix-4 divider (nine steps), two multiply stages, one store
// read, then the output register. Throughput: one load per cycle while the
// output beat is free; an emit holds the input until its result is registered.
// Reset: asynchronous, active low; registers return to 1, counters and write
// pointer to zero. The pixel store is not cleared.
module nearest_neighbor_resize
    import nnr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // APB configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [PIX_W-1:0]    s_axis_tdata,   // pixel_in
    input  logic                s_axis_tuser,   // command
    // output stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [63:0]         m_axis_tdata,   // pixel_out, out_batch, out_channel,
                                                // out_row, out_col, zero pad
    output logic                m_axis_tlast,   // last_output
    output logic                m_axis_tuser    // store_full
);

    logic [DIM_W-1:0]    in_height_reg, in_width_reg, out_height_reg, out_width_reg;
    logic [DIM_W-1:0]    channel_count_reg;
    logic [BATCH_W-1:0]  batch_count_reg;

    logic [DIM_W-1:0]    in_h, in_w, out_h, out_w, chans;
    logic [BATCH_W-1:0]  batches;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg;

    logic [WP_W-1:0]     wp_reg;
    logic [BCNT_W-1:0]   batch_reg;
    logic [CNT_W-1:0]    chan_reg, row_reg, col_reg;

    div_t                row_div_reg, col_div_reg;
    logic [A1_W-1:0]     t1_reg;
    logic [A2_W-1:0]     t2_reg;
    logic [A3_W-1:0]     t3_reg;
    logic [CNT_W-1:0]    sw_reg;

    logic                out_valid_reg;
    logic [PIX_W-1:0]    out_pixel_reg;
    logic [BCNT_W-1:0]   out_batch_reg;
    logic [CNT_W-1:0]    out_chan_reg, out_row_reg, out_col_reg;
    logic                out_last_reg, out_full_reg;

    logic [PIX_W-1:0]    pixel_store [STORE_WORDS];
    logic [PIX_W-1:0]    rd_q;

    logic                cfg_wr, s_fire, load_fire, emit_fire, out_free, emit_done;
    logic                store_room, is_last, addr_ok;
    logic [CNT_W-1:0]    sh;
    logic [2*CNT_W-1:0]  row_prod, col_prod;
    div_t                row_div_step, col_div_step;
    logic [DIM_W-1:0]    col_inc, row_inc, chan_inc;
    logic [BATCH_W-1:0]  batch_inc;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg     <= DIM_W'(1);
            in_width_reg      <= DIM_W'(1);
            out_height_reg    <= DIM_W'(1);
            out_width_reg     <= DIM_W'(1);
            channel_count_reg <= DIM_W'(1);
            batch_count_reg   <= BATCH_W'(1);
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_IN_HEIGHT:     in_height_reg     <= pwdata[DIM_W-1:0];
                REG_IN_WIDTH:      in_width_reg      <= pwdata[DIM_W-1:0];
                REG_OUT_HEIGHT:    out_height_reg    <= pwdata[DIM_W-1:0];
                REG_OUT_WIDTH:     out_width_reg     <= pwdata[DIM_W-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[DIM_W-1:0];
                REG_BATCH_COUNT:   batch_count_reg   <= pwdata[BATCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_IN_HEIGHT:     prdata = PDATA_W'(in_height_reg);
            REG_IN_WIDTH:      prdata = PDATA_W'(in_width_reg);
            REG_OUT_HEIGHT:    prdata = PDATA_W'(out_height_reg);
            REG_OUT_WIDTH:     prdata = PDATA_W'(out_width_reg);
            REG_CHANNEL_COUNT: prdata = PDATA_W'(channel_count_reg);
            REG_BATCH_COUNT:   prdata = PDATA_W'(batch_count_reg);
            default:           prdata = '0;
        endcase
    end

    assign in_h    = clamp_dim(in_height_reg);
    assign in_w    = clamp_dim(in_width_reg);
    assign out_h   = clamp_dim(out_height_reg);
    assign out_w   = clamp_dim(out_width_reg);
    assign chans   = clamp_dim(channel_count_reg);
    assign batches = clamp_batch(batch_count_reg);

    // ---------------- handshakes ----------------
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) &&
                           ((cmd_t'(s_axis_tuser) == CMD_EMIT) || out_free);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign load_fire     = s_fire && (cmd_t'(s_axis_tuser) == CMD_LOAD);
    assign emit_fire     = s_fire && (cmd_t'(s_axis_tuser) == CMD_EMIT);
    assign emit_done     = (state_reg == ST_OUT) && out_free;
    assign store_room    = wp_reg < WP_W'(STORE_WORDS);

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (emit_fire)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_MUL_ROW;
            end
            ST_MUL_ROW: state_next = ST_MUL_COL;
            ST_MUL_COL: state_next = ST_READ;
            ST_READ:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (state_reg == ST_DIV)
            step_reg <= step_reg + STEP_W'(1);
        else
            step_reg <= '0;
    end

    // ---------------- source index and address ----------------
    assign row_prod     = row_reg * CNT_W'(in_h - DIM_W'(1));  // row * (in_h - 1)
    assign col_prod     = col_reg * CNT_W'(in_w - DIM_W'(1));
    assign row_div_step = div_step2(row_div_reg, (out_h - DIM_W'(1)) << 1);
    assign col_div_step = div_step2(col_div_reg, (out_w - DIM_W'(1)) << 1);
    assign sh           = src_clamp(row_div_reg.quo, in_h, out_h);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                row_div_reg.rem <= '0;
                row_div_reg.quo <= '0;
                row_div_reg.num <= {1'b0, row_prod, 1'b0} + NUM_W'(out_h - DIM_W'(1));
                col_div_reg.rem <= '0;
                col_div_reg.quo <= '0;
                col_div_reg.num <= {1'b0, col_prod, 1'b0} + NUM_W'(out_w - DIM_W'(1));
                t1_reg          <= A1_W'(batch_reg * chans) + A1_W'(chan_reg);
            end
            ST_DIV:
            begin
                row_div_reg <= row_div_step;
                col_div_reg <= col_div_step;
            end
            ST_MUL_ROW:
            begin
                t2_reg <= A2_W'(t1_reg * in_h) + A2_W'(sh);
                sw_reg <= src_clamp(col_div_reg.quo, in_w, out_w);
            end
            ST_MUL_COL:
            begin
                t3_reg <= A3_W'(t2_reg * in_w) + A3_W'(sw_reg);
            end
            default: ;
        endcase
    end

    assign addr_ok = t3_reg < A3_W'(STORE_WORDS);

    // ---------------- pixel store ----------------
    always_ff @(posedge clk)
    begin
        if (load_fire && store_room)
            pixel_store[wp_reg[STORE_AW-1:0]] <= s_axis_tdata;
        rd_q <= pixel_store[t3_reg[STORE_AW-1:0]];
    end

    // ---------------- counters ----------------
    assign col_inc   = DIM_W'(col_reg) + DIM_W'(1);
    assign row_inc   = DIM_W'(row_reg) + DIM_W'(1);
    assign chan_inc  = DIM_W'(chan_reg) + DIM_W'(1);
    assign batch_inc = BATCH_W'(batch_reg) + BATCH_W'(1);
    assign is_last   = (batch_inc >= batches) && (chan_inc >= chans) &&
                       (row_inc >= out_h) && (col_inc >= out_w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            batch_reg <= '0;
            chan_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else if (load_fire)
        begin
            if (store_room)
                wp_reg <= wp_reg + WP_W'(1);
        end
        else if (emit_done)
        begin
            if (is_last)
            begin
                wp_reg    <= '0;
                batch_reg <= '0;
                chan_reg  <= '0;
                row_reg   <= '0;
                col_reg   <= '0;
            end
            else if (col_inc < out_w)
                col_reg <= col_inc[CNT_W-1:0];
            else
            begin
                col_reg <= '0;
                if (row_inc < out_h)
                    row_reg <= row_inc[CNT_W-1:0];
                else
                begin
                    row_reg <= '0;
                    if (chan_inc < chans)
                        chan_reg <= chan_inc[CNT_W-1:0];
                    else
                    begin
                        chan_reg <= '0;
                        if (batch_inc < batches)
                            batch_reg <= batch_inc[BCNT_W-1:0];
                        else
                            batch_reg <= '0;
                    end
                end
            end
        end
    end

    // ---------------- output beat register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_fire || emit_done)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            out_pixel_reg <= '0;
            out_batch_reg <= '0;
            out_chan_reg  <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_last_reg  <= 1'b0;
            out_full_reg  <= !store_room;
        end
        else if (emit_done)
        begin
            out_pixel_reg <= addr_ok ? rd_q : '0;
            out_batch_reg <= batch_reg;
            out_chan_reg  <= chan_reg;
            out_row_reg   <= row_reg;
            out_col_reg   <= col_reg;
            out_last_reg  <= is_last;
            out_full_reg  <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_col_reg, out_row_reg, out_chan_reg,
                            out_batch_reg, out_pixel_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_full_reg;

endmodule

// ===== tb/sv/nearest_neighbor_resize_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nearest_neighbor_resize: loads and emits over the
// stream ports, geometry over APB, every output beat checked against a local
// predictor. Depends on nnr_pkg and the nearest_neighbor_resize RTL.
module nearest_neighbor_resize_tb
    import nnr_pkg::*;
();

    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [31:0] pixel;
        logic [3:0]  batch;
        logic [7:0]  chan;
        logic [7:0]  row;
        logic [7:0]  col;
        logic        last;
        logic        full;
    } resize_beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [PIX_W-1:0]   s_axis_tdata = '0;   // pixel_in
    logic               s_axis_tuser = 1'b0; // command
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b1;
    logic [63:0]        m_axis_tdata;        // pixel_out, out_batch, out_channel,
                                             // out_row, out_col, zero pad
    logic               m_axis_tlast;        // last_output
    logic               m_axis_tuser;        // store_full

    // predictor state
    logic [31:0]  pixel_mem [0:STORE_WORDS-1];
    bit           mem_written [0:STORE_WORDS-1];
    int           wr_ptr;
    int           b_cnt;
    int           c_cnt;
    int           r_cnt;
    int           k_cnt;
    int unsigned  reg_val [0:5];

    resize_beat_t expected_pixels [$];
    int           error_count = 0;
    int           n_items = 0;
    int           n_loads = 0;
    int           n_emits = 0;
    int           n_full = 0;
    int           n_last = 0;
    int           n_cfg = 0;
    int           burst_left = 0;
    int           rx_mode = 0;
    int           rx_left = 0;
    int           idle_cycles = 0;

    nearest_neighbor_resize u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint eff_dim(int unsigned v, int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    // aligned corners, round half up, clamped to the last source line
    function automatic longint nearest_src(longint i, longint in_n, longint out_n);
        longint s;
        if (out_n <= 1)
            return 0;
        s = (2 * i * (in_n - 1) + (out_n - 1)) / (2 * (out_n - 1));
        if (s > in_n - 1)
            s = in_n - 1;
        return s;
    endfunction

    function automatic longint source_addr();
        longint in_h;
        longint in_w;
        in_h = eff_dim(reg_val[REG_IN_HEIGHT], MAX_DIM);
        in_w = eff_dim(reg_val[REG_IN_WIDTH], MAX_DIM);
        return ((longint'(b_cnt) * eff_dim(reg_val[REG_CHANNEL_COUNT], MAX_DIM) + c_cnt)
                * in_h + nearest_src(r_cnt, in_h, eff_dim(reg_val[REG_OUT_HEIGHT], MAX_DIM)))
               * in_w + nearest_src(k_cnt, in_w, eff_dim(reg_val[REG_OUT_WIDTH], MAX_DIM));
    endfunction

    function automatic bit emit_is_safe();
        longint a;
        a = source_addr();
        return (a >= STORE_WORDS) || mem_written[a];
    endfunction

    function automatic longint frame_inputs();
        return eff_dim(reg_val[REG_BATCH_COUNT], MAX_BATCH)
               * eff_dim(reg_val[REG_CHANNEL_COUNT], MAX_DIM)
               * eff_dim(reg_val[REG_IN_HEIGHT], MAX_DIM)
               * eff_dim(reg_val[REG_IN_WIDTH], MAX_DIM);
    endfunction

    function automatic longint frame_outputs();
        return eff_dim(reg_val[REG_BATCH_COUNT], MAX_BATCH)
               * eff_dim(reg_val[REG_CHANNEL_COUNT], MAX_DIM)
               * eff_dim(reg_val[REG_OUT_HEIGHT], MAX_DIM)
               * eff_dim(reg_val[REG_OUT_WIDTH], MAX_DIM);
    endfunction

    function automatic resize_beat_t resize_predict(cmd_t cmd, logic [31:0] px);
        resize_beat_t r;
        longint       a;
        longint       out_h;
        longint       out_w;
        longint       chans;
        longint       batches;
        r = '0;
        if (cmd == CMD_LOAD)
        begin
            if (wr_ptr < STORE_WORDS)
            begin
                pixel_mem[wr_ptr]   = px;
                mem_written[wr_ptr] = 1'b1;
                wr_ptr++;
            end
            else
                r.full = 1'b1;
            return r;
        end
        out_h   = eff_dim(reg_val[REG_OUT_HEIGHT], MAX_DIM);
        out_w   = eff_dim(reg_val[REG_OUT_WIDTH], MAX_DIM);
        chans   = eff_dim(reg_val[REG_CHANNEL_COUNT], MAX_DIM);
        batches = eff_dim(reg_val[REG_BATCH_COUNT], MAX_BATCH);
        a = source_addr();
        if (a < STORE_WORDS)
            r.pixel = pixel_mem[a];
        r.batch = 4'(b_cnt);
        r.chan  = 8'(c_cnt);
        r.row   = 8'(r_cnt);
        r.col   = 8'(k_cnt);
        r.last  = (b_cnt + 1 >= batches) && (c_cnt + 1 >= chans) &&
                  (r_cnt + 1 >= out_h) && (k_cnt + 1 >= out_w);
        if (r.last)
        begin
            b_cnt  = 0;
            c_cnt  = 0;
            r_cnt  = 0;
            k_cnt  = 0;
            wr_ptr = 0;
            return r;
        end
        k_cnt++;
        if (k_cnt >= out_w)
        begin
            k_cnt = 0;
            r_cnt++;
            if (r_cnt >= out_h)
            begin
                r_cnt = 0;
                c_cnt++;
                if (c_cnt >= chans)
                begin
                    c_cnt = 0;
                    b_cnt++;
                    if (b_cnt >= batches)
                        b_cnt = 0;
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic send_beat(cmd_t cmd, logic [31:0] px);
        int           gap;
        resize_beat_t r;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        // never read back a store word that has not been loaded yet
        if (cmd == CMD_EMIT && !emit_is_safe())
        begin
            cmd = CMD_LOAD;
            px  = $urandom();
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= px;
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = resize_predict(cmd, px);
        expected_pixels.push_back(r);
        n_items++;
        if (cmd == CMD_LOAD)
            n_loads++;
        else
            n_emits++;
        n_full += int'(r.full);
        n_last += int'(r.last);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int unsigned val);
        logic [31:0] mask;
        mask = (idx == REG_BATCH_COUNT) ? 32'h1F : 32'h1FF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        reg_val[idx] = val & mask;
        n_cfg++;
        // read back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("prdata", 64'(val & mask), 64'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_geometry(int unsigned ih, int unsigned iw, int unsigned oh,
                                int unsigned ow, int unsigned ch, int unsigned bt);
        write_reg(REG_IN_HEIGHT, ih);
        write_reg(REG_IN_WIDTH, iw);
        write_reg(REG_OUT_HEIGHT, oh);
        write_reg(REG_OUT_WIDTH, ow);
        write_reg(REG_CHANNEL_COUNT, ch);
        write_reg(REG_BATCH_COUNT, bt);
    endtask

    task automatic load_words(longint n);
        for (longint k = 0; k < n; k++)
            send_beat(CMD_LOAD, $urandom());
    endtask

    task automatic emit_beats(longint n);
        for (longint k = 0; k < n; k++)
            send_beat(CMD_EMIT, $urandom());
    endtask

    task automatic finish_frame();
        int seen;
        seen = n_last;
        while (n_last == seen)
            send_beat(CMD_EMIT, $urandom());
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_defaults();
        send_beat(CMD_LOAD, 32'hFFFF_FFFF);
        send_beat(CMD_EMIT, 32'h0);
        send_beat(CMD_LOAD, 32'h0);
        send_beat(CMD_EMIT, 32'hFFFF_FFFF);
        send_beat(CMD_EMIT, $urandom());
        wait_drained();
    endtask

    // 256x256 plane (over-range values), 2x2 out: lower corners fall past the store
    task automatic test_beyond_store();
        set_geometry(511, 300, 2, 2, 0, 0);
        load_words(256);
        emit_beats(4);
        wait_drained();
    endtask

    task automatic test_extreme_extents();
        set_geometry(256, 1, 256, 1, 1, 1);
        load_words(256);
        emit_beats(256);
        wait_drained();
        set_geometry(1, 2, 1, 256, 1, 1);
        load_words(2);
        emit_beats(256);
        wait_drained();
        set_geometry(1, 256, 1, 2, 1, 1);
        load_words(256);
        emit_beats(2);
        wait_drained();
        set_geometry(1, 1, 1, 1, 1, 16);
        load_words(16);
        emit_beats(16);
        wait_drained();
    endtask

    // shrink out_height while the row counter is past it
    task automatic test_midstream_resize();
        set_geometry(4, 4, 8, 8, 1, 1);
        load_words(16);
        emit_beats(40);
        wait_drained();
        write_reg(REG_OUT_HEIGHT, 3);
        finish_frame();
        wait_drained();
    endtask

    task automatic test_random_frames(int target);
        int     start;
        int     mode;
        longint n_in;
        longint n_out;
        start = n_items;
        while (n_items - start < target)
        begin
            wait_drained();
            set_geometry($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 8),
                         $urandom_range(1, 8), $urandom_range(1, 3), $urandom_range(1, 3));
            if ($urandom_range(0, 7) == 0)
                write_reg(reg_idx_t'($urandom_range(0, 5)), 0);
            n_in  = frame_inputs();
            n_out = frame_outputs();
            mode  = $urandom_range(0, 7);
            if (mode == 0)
            begin
                // noise
                for (longint k = 0; k < n_out; k++)
                    send_beat(cmd_t'($urandom_range(0, 1)), $urandom());
            end
            else
            begin
                for (longint k = 0; k < n_in; k++)
                begin
                    send_beat(CMD_LOAD, $urandom());
                    if ($urandom_range(0, 31) == 0)
                        send_beat(CMD_EMIT, $urandom());
                end
                // broken frame: stop early, next geometry lands mid-stream
                if (mode == 1)
                    n_out = $urandom_range(0, n_out - 1);
                for (longint k = 0; k < n_out; k++)
                begin
                    send_beat(CMD_EMIT, $urandom());
                    if ($urandom_range(0, 23) == 0)
                        wait_drained();
                end
            end
        end
        wait_drained();
    endtask

    // 4096 planes of 1x1; overflow the store, then cut the geometry mid-frame
    task automatic test_store_full();
        set_geometry(0, 1, 0, 1, 256, 31);
        load_words(STORE_WORDS + 3);
        emit_beats(300);
        wait_drained();
        write_reg(REG_CHANNEL_COUNT, 8);
        write_reg(REG_BATCH_COUNT, 2);
        finish_frame();
        wait_drained();
    endtask

    // ------------------------------------------------------------ checking

    always @(posedge clk)
    begin : check_results
        resize_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected output beat: expected none, got tdata 0x%0h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("pixel_out", 64'(want.pixel), 64'(m_axis_tdata[31:0]));
                check_field("out_batch", 64'(want.batch), 64'(m_axis_tdata[35:32]));
                check_field("out_channel", 64'(want.chan), 64'(m_axis_tdata[43:36]));
                check_field("out_row", 64'(want.row), 64'(m_axis_tdata[51:44]));
                check_field("out_col", 64'(want.col), 64'(m_axis_tdata[59:52]));
                check_field("tdata pad", 64'h0, 64'(m_axis_tdata[63:60]));
                check_field("last_output", 64'(want.last), 64'(m_axis_tlast));
                check_field("store_full", 64'(want.full), 64'(m_axis_tuser));
            end
        end
    end

    // receiver back-pressure: runs of always-ready, half-ready and mostly-stalled
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(4, 40);
        end
        rx_left--;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, expected_pixels.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        wr_ptr = 0;
        b_cnt  = 0;
        c_cnt  = 0;
        r_cnt  = 0;
        k_cnt  = 0;
        for (int k = 0; k < 6; k++)
            reg_val[k] = 1;
        for (int k = 0; k < STORE_WORDS; k++)
            mem_written[k] = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_beyond_store();
        test_extreme_extents();
        test_midstream_resize();
        test_random_frames(1300);
        test_store_full();

        wait_drained();
        repeat (20) @(posedge clk);
        $display("Run covered %0d loads (%0d dropped on a full store) and %0d emits,",
                 n_loads, n_full, n_emits);
        $display("%0d completed output frames and %0d register writes with read-back.",
                 n_last, n_cfg);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== nearest_neighbor_resize.f =====
sv/nnr_pkg.sv
sv/nearest_neighbor_resize.sv
tb/sv/nearest_neighbor_resize_tb.sv
